@@ hw/rtl/salru_pkg.sv @@
`default_nettype none

package salru_pkg;

    // Default sizes
    localparam int DEF_SETS         = 256;
    localparam int DEF_WAYS         = 8;
    localparam int DEF_ADDRESS_BITS = 64;

    // Fixed field widths
    localparam int ADDR_W       = 64;
    localparam int ACTION_W     = 2;
    localparam int OUTCOME_W    = 2;
    localparam int COUNT_W      = 32;
    localparam int STAMP_W      = 64;
    localparam int SET_BITS_W   = 4;
    localparam int BLOCK_BITS_W = 6;
    localparam int WAYS_CFG_W   = 4;
    localparam int CFG_DATA_W   = 6;
    localparam int CFG_INDEX_W  = 2;

    // Shift amounts at or above this leave no tag bits
    localparam int WORD_BITS = 64;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAYS       = 2'd2;

    // Register reset values
    localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 4'd4;
    localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 6'd4;
    localparam logic [WAYS_CFG_W-1:0]   WAYS_RST       = 4'd1;

    // Action codes; the unused code behaves as a load
    localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_STORE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_MODIFY = 2'd2;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } outcome_t;

    // Set lookup result, exactly one flag set
    typedef struct packed {
        logic hit;
        logic fill;
        logic evict;
    } status_t;

endpackage

`default_nettype wire

@@ hw/rtl/salru_ram.sv @@
`default_nettype none

module salru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic                                     re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/salru_lookup.sv @@
`default_nettype none

// Way compare and replacement choice for one set row.
module salru_lookup #(
    parameter int WAYS  = 8,
    parameter int TAG_W = 64
) (
    input  wire logic [WAYS-1:0]                          used,
    input  wire logic [WAYS-1:0]                          valid,
    input  wire logic [WAYS-1:0][TAG_W-1:0]               tags,
    input  wire logic [WAYS-1:0][salru_pkg::STAMP_W-1:0]  stamps,
    input  wire logic [TAG_W-1:0]                         tag,
    output salru_pkg::status_t                            status,
    output logic      [WAYS-1:0]                          way_sel
);

    import salru_pkg::*;

    logic [WAYS-1:0] match;
    logic [WAYS-1:0] empty;
    logic [WAYS-1:0] hit_sel;
    logic [WAYS-1:0] fill_sel;
    logic [WAYS-1:0] lru_sel;
    logic            seen;

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            match[i] = used[i] & valid[i] & (tags[i] == tag);
            empty[i] = used[i] & ~valid[i];
        end
    end

    // lowest matching way
    assign hit_sel = match & (~match + WAYS'(1));

    // highest empty way
    always_comb
    begin
        seen = 1'b0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            fill_sel[i] = empty[i] & ~seen;
            seen        = seen | empty[i];
        end
    end

    // oldest stamp, highest way on a tie: strictly below higher ways,
    // not above lower ones
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            lru_sel[i] = used[i];
            for (int j = 0; j < WAYS; j++)
            begin
                if (used[j] && j > i)
                begin
                    lru_sel[i] = lru_sel[i] & (stamps[i] < stamps[j]);
                end
                else if (used[j] && j < i)
                begin
                    lru_sel[i] = lru_sel[i] & (stamps[i] <= stamps[j]);
                end
            end
        end
    end

    always_comb
    begin
        status.hit   = |match;
        status.fill  = ~(|match) & (|empty);
        status.evict = ~(|match) & ~(|empty);
        priority if (status.hit)
        begin
            way_sel = hit_sel;
        end
        else if (status.fill)
        begin
            way_sel = fill_sel;
        end
        else
        begin
            way_sel = lru_sel;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/set_assoc_lru_cache_model.sv @@
`default_nettype none

// Set-associative cache model with LRU replacement. Each input beat is one
// access (load, store or modify) to a byte address; each access returns one
// output beat with the outcome of its first lookup (hit, miss into an empty
// way, miss with eviction) and the saturating hit, miss and eviction totals.
// The whole cache lives in one memory, one row per set holding valid, tag and
// stamp for every way. The set row is read in the accept cycle, compared,
// updated and written back in the next, and no new beat is taken during
// the write-back. A modify updates the row once, as a miss or hit followed
// by a second hit. After reset the block clears the memory, one row per
// cycle, with in_stall high; configuration writes are taken during that
// pass. Configure only while idle.
module set_assoc_lru_cache_model #(
    parameter int SETS         = salru_pkg::DEF_SETS,
    parameter int WAYS         = salru_pkg::DEF_WAYS,
    parameter int ADDRESS_BITS = salru_pkg::DEF_ADDRESS_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // config write port
    input  wire logic                                cfg_write,
    input  wire logic [salru_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [salru_pkg::CFG_DATA_W-1:0]    cfg_data,
    // access channel
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [salru_pkg::ACTION_W-1:0]      action,
    input  wire logic [salru_pkg::ADDR_W-1:0]        address,
    // result channel
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic      [salru_pkg::OUTCOME_W-1:0]     outcome,
    output logic      [salru_pkg::COUNT_W-1:0]       hit_count,
    output logic      [salru_pkg::COUNT_W-1:0]       miss_count,
    output logic      [salru_pkg::COUNT_W-1:0]       eviction_count
);

    import salru_pkg::*;

    localparam int SET_W  = $clog2(SETS > 1 ? SETS : 2);
    localparam int MAX_SB = $clog2(SETS + 1) - 1;   // largest k with 2^k <= SETS
    localparam int TAG_W  = ADDRESS_BITS;
    localparam int LINE_W = 1 + TAG_W + STAMP_W;    // {valid, tag, stamp}
    localparam int ROW_W  = WAYS * LINE_W;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SET_BITS_W-1:0]   set_bits_reg;
    logic [BLOCK_BITS_W-1:0] block_bits_reg;
    logic [WAYS_CFG_W-1:0]   ways_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= SET_BITS_RST;
            block_bits_reg <= BLOCK_BITS_RST;
            ways_reg       <= WAYS_RST;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_SET_BITS)
            begin
                set_bits_reg <= cfg_data[SET_BITS_W-1:0];
            end
            if (cfg_index == CFG_BLOCK_BITS)
            begin
                block_bits_reg <= cfg_data[BLOCK_BITS_W-1:0];
            end
            if (cfg_index == CFG_WAYS)
            begin
                ways_reg <= cfg_data[WAYS_CFG_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    state_t                state_reg,     state_next;
    logic                  out_valid_reg, out_valid_next;
    logic [SET_W-1:0]      clr_idx_reg,   clr_idx_next;
    logic [STAMP_W-1:0]    clock_reg,     clock_next;
    logic [COUNT_W-1:0]    hits_reg,      hits_next;
    logic [COUNT_W-1:0]    misses_reg,    misses_next;
    logic [COUNT_W-1:0]    evicts_reg,    evicts_next;

    // access in flight
    logic [SET_W-1:0]      set_reg;
    logic [TAG_W-1:0]      tag_reg;
    logic                  modify_reg;
    outcome_t              outcome_reg;

    logic                  accept;
    logic                  out_take;

    // only accept when the result slot is free by the lookup cycle
    assign in_stall = ~((state_reg == ST_IDLE) & (~out_valid_reg | ~out_stall));
    assign accept   = in_valid & ~in_stall;
    assign out_take = out_valid_reg & ~out_stall;

    // ------------------------------------------------------------------
    // Address split: offset | set | tag, from the low end
    // ------------------------------------------------------------------
    logic [TAG_W-1:0]   addr_a;
    logic [4:0]         sb_eff;
    logic [TAG_W-1:0]   shifted;
    logic [SET_W:0]     set_mask;
    logic [SET_W-1:0]   set_idx;
    logic [6:0]         tag_sum;
    logic [TAG_W-1:0]   tag_calc;

    assign addr_a = address[TAG_W-1:0];

    always_comb
    begin
        if ({1'b0, set_bits_reg} > 5'(MAX_SB))
        begin
            sb_eff = 5'(MAX_SB);
        end
        else
        begin
            sb_eff = {1'b0, set_bits_reg};
        end
        shifted  = addr_a >> block_bits_reg;
        set_mask = ((SET_W + 1)'(1) << sb_eff) - (SET_W + 1)'(1);
        set_idx  = shifted[SET_W-1:0] & set_mask[SET_W-1:0];
        tag_sum  = {2'b00, sb_eff} + {1'b0, block_bits_reg};
        if (tag_sum >= 7'(WORD_BITS))
        begin
            tag_calc = '0;
        end
        else
        begin
            tag_calc = addr_a >> tag_sum;
        end
    end

    // ------------------------------------------------------------------
    // Set memory
    // ------------------------------------------------------------------
    logic              ram_we;
    logic [SET_W-1:0]  ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;
    logic [ROW_W-1:0]  rd_row;
    logic [ROW_W-1:0]  new_row;

    salru_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (set_idx),
        .rdata (rd_row)
    );

    // ------------------------------------------------------------------
    // Lookup on the row read back
    // ------------------------------------------------------------------
    logic [WAYS-1:0]               used;
    logic [WAYS-1:0]               rd_valid;
    logic [WAYS-1:0][TAG_W-1:0]    rd_tag;
    logic [WAYS-1:0][STAMP_W-1:0]  rd_stamp;
    logic [WAYS-1:0]               way_sel;
    status_t                       status;
    logic [STAMP_W-1:0]            stamp_new;

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            rd_valid[i] = rd_row[i * LINE_W + LINE_W - 1];
            rd_tag[i]   = rd_row[i * LINE_W + STAMP_W +: TAG_W];
            rd_stamp[i] = rd_row[i * LINE_W +: STAMP_W];
            // zero ways act as one; values above WAYS fall away naturally
            used[i]     = (i == 0) | (7'(i) < {3'b000, ways_reg});
        end
    end

    salru_lookup #(
        .WAYS  (WAYS),
        .TAG_W (TAG_W)
    ) u_lookup (
        .used    (used),
        .valid   (rd_valid),
        .tags    (rd_tag),
        .stamps  (rd_stamp),
        .tag     (tag_reg),
        .status  (status),
        .way_sel (way_sel)
    );

    // a modify is a second access that hits the same way one tick later
    assign stamp_new = clock_reg + (modify_reg ? STAMP_W'(2) : STAMP_W'(1));

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            if (way_sel[i])
            begin
                new_row[i * LINE_W +: LINE_W] = {1'b1, tag_reg, stamp_new};
            end
            else
            begin
                new_row[i * LINE_W +: LINE_W] = rd_row[i * LINE_W +: LINE_W];
            end
        end
    end

    always_comb
    begin
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                ram_wdata = '0;
            end
            ST_LOOKUP:
            begin
                ram_we    = 1'b1;
                ram_waddr = set_reg;
                ram_wdata = new_row;
            end
            default:
            begin
                ram_we    = 1'b0;
                ram_waddr = set_reg;
                ram_wdata = new_row;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Totals
    // ------------------------------------------------------------------
    function automatic logic [COUNT_W-1:0] sat_add(
        input logic [COUNT_W-1:0] v,
        input logic [1:0]         n
    );
        logic [COUNT_W:0] sum;
        sum = {1'b0, v} + (COUNT_W + 1)'(n);
        return sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
    endfunction

    logic [1:0] hit_add;

    assign hit_add = {1'b0, status.hit} + {1'b0, modify_reg};

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg & ~out_take;
        clr_idx_next   = clr_idx_reg;
        clock_next     = clock_reg;
        hits_next      = hits_reg;
        misses_next    = misses_reg;
        evicts_next    = evicts_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + SET_W'(1);
                if (clr_idx_reg == SET_W'(SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                clock_next     = stamp_new;
                hits_next      = sat_add(hits_reg, hit_add);
                misses_next    = sat_add(misses_reg, {1'b0, ~status.hit});
                evicts_next    = sat_add(evicts_reg, {1'b0, status.evict});
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
            clr_idx_reg   <= '0;
            clock_reg     <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            evicts_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            clr_idx_reg   <= clr_idx_next;
            clock_reg     <= clock_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            evicts_reg    <= evicts_next;
        end
    end

    // payload: access fields at accept, outcome at write-back
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg    <= set_idx;
            tag_reg    <= tag_calc;
            modify_reg <= (action == ACT_MODIFY);
        end
        if (state_reg == ST_LOOKUP)
        begin
            priority if (status.hit)
            begin
                outcome_reg <= OUT_HIT;
            end
            else if (status.fill)
            begin
                outcome_reg <= OUT_FILL;
            end
            else
            begin
                outcome_reg <= OUT_EVICT;
            end
        end
    end

    // totals only move in a lookup, which waits for the slot, so they
    // hold steady while a beat is stalled
    assign out_valid      = out_valid_reg;
    assign outcome        = outcome_reg;
    assign hit_count      = hits_reg;
    assign miss_count     = misses_reg;
    assign eviction_count = evicts_reg;

endmodule

`default_nettype wire
